// ===== rtl/bpc_pkg.sv =====
`timescale 1ns / 1ps
// bpc_pkg: constants, calibration reset values and helper functions
// for the pressure compensation pipeline. No dependencies.
package bpc_pkg;
    localparam int unsigned CAL_REGS = 5;
    localparam int unsigned CAL_IDX_W = 3;
    localparam int unsigned DIV_W = 32;

    localparam logic [31:0] CAL0_RST = 32'd26804152;
    localparam logic [31:0] CAL1_RST = 32'd3352395749;
    localparam logic [31:0] CAL2_RST = 32'd2146785905;
    localparam logic [31:0] CAL3_RST = 32'd405667844;
    localparam logic [31:0] CAL4_RST = 32'd3724086068;

    localparam logic [CAL_IDX_W-1:0] IDX_AC1_AC2 = 3'd0;
    localparam logic [CAL_IDX_W-1:0] IDX_AC3_AC4 = 3'd1;
    localparam logic [CAL_IDX_W-1:0] IDX_AC5_AC6 = 3'd2;
    localparam logic [CAL_IDX_W-1:0] IDX_B1_B2   = 3'd3;
    localparam logic [CAL_IDX_W-1:0] IDX_MC_MD   = 3'd4;

    typedef struct packed {
        logic [31:0] ac1_ac2;
        logic [31:0] ac3_ac4;
        logic [31:0] ac5_ac6;
        logic [31:0] b1_b2;
        logic [31:0] mc_md;
    } cal_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction
endpackage

// ===== rtl/barometric_pressure_compensation_top.sv =====
`timescale 1ns / 1ps
// Top level: fixed-point temperature and pressure compensation pipeline.
// Depends on bpc_pkg and bpc_udiv (two 32-stage dividers).
//
// channel | dir | tdata (low bit up)                               | tuser
// s_      | in  | raw_temp[15:0], raw_pressure[34:16]              | oversampling[1:0]
// m_      | out | temperature[31:0], pressure[63:32]               | div_error
// cfg     | in  | cfg_we, cfg_index, cfg_data (calibration)        | -
//
// One request per cycle while m_ is not stalled; the path holds two 32-stage dividers.
// aresetn is synchronous: it clears all valid bits, and the calibration
// registers return to their defaults. A stall on m_ freezes the whole pipe.
module barometric_pressure_compensation_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [bpc_pkg::CAL_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [39:0]                    s_tdata,   // raw_temp, raw_pressure
    input  logic [1:0]                     s_tuser,   // oversampling
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [63:0]                    m_tdata,   // temperature, pressure
    output logic                           m_tuser    // div_error
);
    import bpc_pkg::*;

    cal_t cal_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '{CAL0_RST, CAL1_RST, CAL2_RST, CAL3_RST, CAL4_RST};
        end else if (cfg_we) begin
            case (cfg_index)
                IDX_AC1_AC2: cal_reg.ac1_ac2 <= cfg_data;
                IDX_AC3_AC4: cal_reg.ac3_ac4 <= cfg_data;
                IDX_AC5_AC6: cal_reg.ac5_ac6 <= cfg_data;
                IDX_B1_B2:   cal_reg.b1_b2 <= cfg_data;
                IDX_MC_MD:   cal_reg.mc_md <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    always_comb begin
        ac1 = sx16(cal_reg.ac1_ac2[31:16]);
        ac2 = sx16(cal_reg.ac1_ac2[15:0]);
        ac3 = sx16(cal_reg.ac3_ac4[31:16]);
        ac4 = {16'd0, cal_reg.ac3_ac4[15:0]};
        ac5 = {16'd0, cal_reg.ac5_ac6[31:16]};
        ac6 = {16'd0, cal_reg.ac5_ac6[15:0]};
        b1 = sx16(cal_reg.b1_b2[31:16]);
        b2 = sx16(cal_reg.b1_b2[15:0]);
        mc = sx16(cal_reg.mc_md[31:16]);
        md = sx16(cal_reg.mc_md[15:0]);
    end

    // output register: pipe advances when output register is free or taken
    logic en;
    logic out_vld_reg;
    logic [63:0] out_data_reg;
    logic out_err_reg;
    assign en = !out_vld_reg || m_tready;
    assign s_tready = en;

    // stage 1: x1 product
    logic v1_reg;
    logic [31:0] x1p_reg;
    logic [18:0] up1_reg;
    logic [1:0] os1_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en) v1_reg <= s_tvalid;
        if (en) begin
            x1p_reg <= ({16'd0, s_tdata[15:0]} - ac6) * ac5;
            up1_reg <= s_tdata[34:16];
            os1_reg <= s_tuser;
        end
    end

    // stage 2: x1, denominator, sign/magnitude
    logic v2_reg;
    logic [31:0] x1t_reg, dent_reg, mnum_reg, mden_reg;
    logic neg_t_reg;
    logic [18:0] up2_reg;
    logic [1:0] os2_reg;
    logic [31:0] x1t_next, den_next, num_next;
    always_comb begin
        x1t_next = $signed(x1p_reg) >>> 15;
        den_next = x1t_next + md;
        num_next = mc << 11;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en) v2_reg <= v1_reg;
        if (en) begin
            x1t_reg <= x1t_next;
            dent_reg <= den_next;
            mnum_reg <= num_next[31] ? -num_next : num_next;
            mden_reg <= den_next[31] ? -den_next : den_next;
            neg_t_reg <= num_next[31] ^ den_next[31];
            up2_reg <= up1_reg;
            os2_reg <= os1_reg;
        end
    end

    localparam int unsigned TPW = 32 + 1 + 1 + 19 + 2;
    logic tq_vld;
    logic [31:0] tq;
    logic [TPW-1:0] tpay;
    logic tz;
    assign tz = (dent_reg == 32'd0);
    bpc_udiv #(.W(DIV_W), .PW(TPW)) u_tdiv (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v2_reg), .in_num(mnum_reg), .in_den(mden_reg),
        .in_pay({x1t_reg, neg_t_reg, tz, up2_reg, os2_reg}),
        .out_valid(tq_vld), .out_quo(tq), .out_pay(tpay)
    );

    // stage 3: b5, temp, b6
    logic v3_reg, e3_reg;
    logic [31:0] temp3_reg, b6_3_reg;
    logic [18:0] up3_reg;
    logic [1:0] os3_reg;
    logic [31:0] x2_next, b5_next;
    always_comb begin
        x2_next = tpay[22] ? -tq : tq;
        b5_next = tpay[TPW-1 -: 32] + x2_next;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (en) v3_reg <= tq_vld;
        if (en) begin
            e3_reg <= tpay[21];
            temp3_reg <= $signed(b5_next + 32'd8) >>> 4;
            b6_3_reg <= b5_next - 32'd4000;
            up3_reg <= tpay[20:2];
            os3_reg <= tpay[1:0];
        end
    end

    // stage 4: b6 products
    logic v4_reg, e4_reg;
    logic [31:0] temp4_reg, b6sqp_reg, ac2b6_reg, ac3b6_reg;
    logic [18:0] up4_reg;
    logic [1:0] os4_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (en) v4_reg <= v3_reg;
        if (en) begin
            e4_reg <= e3_reg;
            temp4_reg <= temp3_reg;
            b6sqp_reg <= b6_3_reg * b6_3_reg;
            ac2b6_reg <= ac2 * b6_3_reg;
            ac3b6_reg <= ac3 * b6_3_reg;
            up4_reg <= up3_reg;
            os4_reg <= os3_reg;
        end
    end

    // stage 5: b6sq products
    logic v5_reg, e5_reg;
    logic [31:0] temp5_reg, b2p_reg, b1p_reg, x2a_reg, x1c_reg;
    logic [18:0] up5_reg;
    logic [1:0] os5_reg;
    logic [31:0] b6sq;
    assign b6sq = $signed(b6sqp_reg) >>> 12;
    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else if (en) v5_reg <= v4_reg;
        if (en) begin
            e5_reg <= e4_reg;
            temp5_reg <= temp4_reg;
            b2p_reg <= b2 * b6sq;
            b1p_reg <= b1 * b6sq;
            x2a_reg <= $signed(ac2b6_reg) >>> 11;
            x1c_reg <= $signed(ac3b6_reg) >>> 13;
            up5_reg <= up4_reg;
            os5_reg <= os4_reg;
        end
    end

    // stage 6: b3 and x3 for b4
    logic v6_reg, e6_reg;
    logic [31:0] temp6_reg, b3_reg, x3b_reg;
    logic [18:0] up6_reg;
    logic [1:0] os6_reg;
    logic [31:0] x3a_next, x3b_next;
    always_comb begin
        x3a_next = $unsigned($signed(b2p_reg) >>> 11) + x2a_reg;
        x3b_next = x1c_reg + $unsigned($signed(b1p_reg) >>> 16) + 32'd2;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v6_reg <= 1'b0;
        else if (en) v6_reg <= v5_reg;
        if (en) begin
            e6_reg <= e5_reg;
            temp6_reg <= temp5_reg;
            b3_reg <= $signed((((ac1 << 2) + x3a_next) << os5_reg) + 32'd2) >>> 2;
            x3b_reg <= $unsigned($signed(x3b_next) >>> 2) + 32'd32768;
            up6_reg <= up5_reg;
            os6_reg <= os5_reg;
        end
    end

    // stage 7: b4 and b7 products
    logic v7_reg, e7_reg;
    logic [31:0] temp7_reg, b4p_reg, b7_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v7_reg <= 1'b0;
        else if (en) v7_reg <= v6_reg;
        if (en) begin
            e7_reg <= e6_reg;
            temp7_reg <= temp6_reg;
            b4p_reg <= ac4 * x3b_reg;
            b7_reg <= ({13'd0, up6_reg} - b3_reg) * (32'd50000 >> os6_reg);
        end
    end

    localparam int unsigned PPW = 32 + 1 + 1;
    logic [31:0] b4;
    logic pz;
    logic pq_vld;
    logic [31:0] pq;
    logic [PPW-1:0] ppay;
    assign b4 = b4p_reg >> 15;
    assign pz = (b4 == 32'd0);
    bpc_udiv #(.W(DIV_W), .PW(PPW)) u_pdiv (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v7_reg),
        .in_num(b7_reg[31] ? b7_reg : (b7_reg << 1)),
        .in_den(b4),
        .in_pay({temp7_reg, b7_reg[31], e7_reg | pz}),
        .out_valid(pq_vld), .out_quo(pq), .out_pay(ppay)
    );

    // stage 8: p products
    logic v8_reg, e8_reg;
    logic [31:0] temp8_reg, p8_reg, pp_reg, p7357_reg;
    logic [31:0] p_next, ps8;
    always_comb begin
        p_next = ppay[1] ? (pq << 1) : pq;
        ps8 = $signed(p_next) >>> 8;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v8_reg <= 1'b0;
        else if (en) v8_reg <= pq_vld;
        if (en) begin
            e8_reg <= ppay[0];
            temp8_reg <= ppay[PPW-1 -: 32];
            p8_reg <= p_next;
            pp_reg <= ps8 * ps8;
            p7357_reg <= (-32'd7357) * p_next;
        end
    end

    // stage 9
    logic v9_reg, e9_reg;
    logic [31:0] temp9_reg, p9_reg, x1m_reg, x2m_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v9_reg <= 1'b0;
        else if (en) v9_reg <= v8_reg;
        if (en) begin
            e9_reg <= e8_reg;
            temp9_reg <= temp8_reg;
            p9_reg <= p8_reg;
            x1m_reg <= pp_reg * 32'd3038;
            x2m_reg <= $signed(p7357_reg) >>> 16;
        end
    end

    logic [31:0] pfin, sum9;
    always_comb begin
        sum9 = $unsigned($signed(x1m_reg) >>> 16) + x2m_reg + 32'd3791;
        pfin = p9_reg + $unsigned($signed(sum9) >>> 4);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) out_vld_reg <= 1'b0;
        else if (en) out_vld_reg <= v9_reg;
        if (en) begin
            out_err_reg <= e9_reg;
            out_data_reg <= e9_reg ? 64'd0 : {pfin, temp9_reg};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata = out_data_reg;
    assign m_tuser = out_err_reg;
endmodule

// ===== rtl/bpc_udiv.sv =====
`timescale 1ns / 1ps
// bpc_udiv: pipelined unsigned restoring divider, one quotient bit per stage.
// Carries a side payload alongside; uses bpc_pkg.
module bpc_udiv #(
    parameter int unsigned W = bpc_pkg::DIV_W,
    parameter int unsigned PW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [W-1:0]  in_num,
    input  logic [W-1:0]  in_den,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [W-1:0]  out_quo,
    output logic [PW-1:0] out_pay
);
    import bpc_pkg::*;

    logic          vld_reg [W+1];
    logic [W-1:0]  num_reg [W+1];
    logic [W-1:0]  rem_reg [W+1];
    logic [W-1:0]  den_reg [W+1];
    logic [PW-1:0] pay_reg [W+1];

    always_comb begin
        vld_reg[0] = in_valid;
        num_reg[0] = in_num;
        rem_reg[0] = '0;
        den_reg[0] = in_den;
        pay_reg[0] = in_pay;
    end

    for (genvar i = 0; i < W; i++) begin : g_stage
        logic [W:0]   trial;
        logic [W:0]   diff;
        logic [W-1:0] rem_next;
        logic [W-1:0] num_next;
        always_comb begin
            trial = {rem_reg[i], num_reg[i][W-1]};
            diff = trial - {1'b0, den_reg[i]};
            if (!diff[W]) begin
                rem_next = diff[W-1:0];
            end else begin
                rem_next = trial[W-1:0];
            end
            num_next = {num_reg[i][W-2:0], ~diff[W]};
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
            if (en) begin
                num_reg[i+1] <= num_next;
                rem_reg[i+1] <= rem_next;
                den_reg[i+1] <= den_reg[i];
                pay_reg[i+1] <= pay_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[W];
    assign out_quo = num_reg[W];
    assign out_pay = pay_reg[W];
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for barometric_pressure_compensation_top: drives raw readings under
// several calibration sets and handshake patterns, checks against a local model.
// Depends on bpc_pkg and the compensation RTL.
module testbench;
    import bpc_pkg::*;

    localparam int LATENCY = 85;
    localparam int WATCHDOG = 20000;

    typedef struct {
        logic [31:0] temperature;
        logic [31:0] pressure;
        logic        div_error;
    } reading_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [CAL_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;

    logic [31:0] cal [CAL_REGS];
    reading_t    pending_readings[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_off = 0;
    int          quiet_cycles = 0;

    always #1 aclk = ~aclk;

    barometric_pressure_compensation_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    function automatic logic [31:0] asr(input logic [31:0] v, input int n);
        asr = $signed(v) >>> n;
    endfunction

    function automatic logic [31:0] sdiv(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        sdiv = (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic reading_t compensate(input logic [15:0] ut, input logic [18:0] up,
                                            input logic [1:0] oss);
        reading_t r;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, den, b5, b6, b6sq, b3, b4, b7, p, t;
        ac1 = {{16{cal[0][31]}}, cal[0][31:16]};
        ac2 = {{16{cal[0][15]}}, cal[0][15:0]};
        ac3 = {{16{cal[1][31]}}, cal[1][31:16]};
        ac4 = {16'd0, cal[1][15:0]};
        ac5 = {16'd0, cal[2][31:16]};
        ac6 = {16'd0, cal[2][15:0]};
        b1  = {{16{cal[3][31]}}, cal[3][31:16]};
        b2  = {{16{cal[3][15]}}, cal[3][15:0]};
        mc  = {{16{cal[4][31]}}, cal[4][31:16]};
        md  = {{16{cal[4][15]}}, cal[4][15:0]};
        r = '{32'd0, 32'd0, 1'b1};
        x1 = asr(({16'd0, ut} - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0) return r;
        x2 = sdiv(mc * 32'd2048, den);
        b5 = x1 + x2;
        t = asr(b5 + 32'd8, 4);
        b6 = b5 - 32'd4000;
        b6sq = asr(b6 * b6, 12);
        x1 = asr(b2 * b6sq, 11);
        x2 = asr(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = asr(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
        x1 = asr(ac3 * b6, 13);
        x2 = asr(b1 * b6sq, 16);
        x3 = asr(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 0) return r;
        b7 = ({13'd0, up} - b3) * (32'd50000 >> oss);
        if (!b7[31]) p = (b7 << 1) / b4;
        else p = (b7 / b4) << 1;
        x1 = asr(p, 8) * asr(p, 8);
        x1 = asr(x1 * 32'd3038, 16);
        x2 = asr((-32'd7357) * p, 16);
        p = p + asr(x1 + x2 + 32'd3791, 4);
        r = '{t, p, 1'b0};
        return r;
    endfunction

    task automatic send_reading(input logic [15:0] ut, input logic [18:0] up,
                                input logic [1:0] oss);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, up, ut};
        s_tuser <= oss;
        pending_readings.push_back(compensate(ut, up, oss));
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        stop_sending();
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic write_cal(input logic [CAL_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx < CAL_REGS) cal[idx] = val;
        @(posedge aclk);
    endtask

    task automatic load_defaults();
        write_cal(IDX_AC1_AC2, CAL0_RST);
        write_cal(IDX_AC3_AC4, CAL1_RST);
        write_cal(IDX_AC5_AC6, CAL2_RST);
        write_cal(IDX_B1_B2, CAL3_RST);
        write_cal(IDX_MC_MD, CAL4_RST);
    endtask

    task automatic send_random(input int n);
        repeat (n) begin
            logic [15:0] ut;
            logic [18:0] up;
            ut = (cal[2] == CAL2_RST) ? 16'($urandom_range(20000, 35000)) : 16'($urandom);
            up = ($urandom_range(3) == 0) ? 19'($urandom) : 19'($urandom_range(20000, 90000));
            send_reading(ut, up, 2'($urandom));
        end
    endtask

    task automatic test_directed_extremes();
        logic [1:0] oss;
        send_reading(16'd27898, 19'd23843, 2'd0);
        send_reading(16'd0, 19'd0, 2'd0);
        send_reading(16'hFFFF, 19'h7FFFF, 2'd3);
        send_reading(16'hFFFF, 19'd0, 2'd1);
        send_reading(16'd0, 19'h7FFFF, 2'd2);
        for (int i = 0; i < 4; i++) begin
            oss = 2'(i);
            send_reading(16'd27898, 19'd40000 << i, oss);
        end
        send_reading(16'h5555, 19'h2AAAA, 2'd1);
        send_reading(16'hAAAA, 19'h55555, 2'd2);
        drain();
    endtask

    task automatic test_zero_divisors();
        // temperature divisor zero: ut == ac6 makes x1 zero, md zero
        write_cal(IDX_MC_MD, 32'h8000_0000);
        send_reading(cal[2][15:0], 19'd30000, 2'd0);
        send_reading(16'd1000, 19'd30000, 2'd1);
        drain();
        // pressure divisor zero: ac4 zero
        write_cal(IDX_MC_MD, CAL4_RST);
        write_cal(IDX_AC3_AC4, 32'hC44B_0000);
        send_reading(16'd27898, 19'd23843, 2'd0);
        drain();
        write_cal(IDX_AC3_AC4, CAL1_RST);
        // out-of-range index is ignored
        write_cal(3'd7, 32'hFFFF_FFFF);
        write_cal(3'd5, 32'd0);
        send_reading(16'd27898, 19'd23843, 2'd2);
        drain();
    endtask

    task automatic test_extreme_calibration();
        write_cal(IDX_AC1_AC2, 32'h7FFF_8000);
        write_cal(IDX_AC3_AC4, 32'h8000_FFFF);
        write_cal(IDX_AC5_AC6, 32'hFFFF_0000);
        write_cal(IDX_B1_B2, 32'h7FFF_7FFF);
        write_cal(IDX_MC_MD, 32'h8000_0001);
        send_random(15);
        drain();
        write_cal(IDX_AC1_AC2, 32'h8000_7FFF);
        write_cal(IDX_AC3_AC4, 32'h7FFF_0001);
        write_cal(IDX_AC5_AC6, 32'h0001_FFFF);
        write_cal(IDX_B1_B2, 32'h8000_8000);
        write_cal(IDX_MC_MD, 32'h7FFF_FFFF);
        send_random(15);
        drain();
    endtask

    task automatic test_random_phases();
        int idle [4] = '{0, 67, 0, 35};
        int stall [4] = '{0, 0, 67, 35};
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle[ph];
            recv_stall_pct = stall[ph];
            if (ph == 2) begin
                for (int i = 0; i < CAL_REGS; i++)
                    write_cal(CAL_IDX_W'(i), $urandom);
            end else begin
                load_defaults();
            end
            send_random(130);
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        load_defaults();
        hold_off = 300;
        send_random(100);
        drain();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected request %h %b", m_tdata, m_tuser);
            end else begin
                want = pending_readings.pop_front();
                if (m_tdata[31:0] !== want.temperature || m_tdata[63:32] !== want.pressure
                        || m_tuser !== want.div_error) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp t=%0d p=%0d e=%b got t=%0d p=%0d e=%b",
                            $signed(want.temperature), $signed(want.pressure),
                            want.div_error, $signed(m_tdata[31:0]),
                            $signed(m_tdata[63:32]), m_tuser);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off > 0)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < CAL_REGS; i++) cal[i] = 32'd0;
        cal[0] = CAL0_RST;
        cal[1] = CAL1_RST;
        cal[2] = CAL2_RST;
        cal[3] = CAL3_RST;
        cal[4] = CAL4_RST;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_extremes();
        test_zero_divisors();
        test_extreme_calibration();
        test_random_phases();
        test_backpressure();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
